@@ hw/rtl/rhc_pkg.sv @@
// shared types, constants and codes for the rainbow hue to rgb colorizer
`timescale 1ns / 1ps

package rhc_pkg;

  localparam int unsigned HUE_FULL      = 360;
  localparam int unsigned SECTOR_SPAN   = 60;
  localparam int unsigned PCT_MAX       = 100;
  localparam int unsigned CHAN_MAX      = 255;
  localparam int unsigned FULL_SCALE    = 6000;

  // floor(x / 360) as (x * RECIP_360) >> SHIFT_360, exact for x below 2**21
  localparam logic [21:0] RECIP_360     = 22'd2982617;
  localparam int unsigned SHIFT_360     = 30;

  // floor(x / 600000) as (x * RECIP_CHAN) >> SHIFT_CHAN, exact for x below 2**28
  localparam logic [28:0] RECIP_CHAN    = 29'd469124962;
  localparam int unsigned SHIFT_CHAN    = 48;

  typedef enum logic [2:0] {
    CFG_HUE_STEP   = 3'd0,
    CFG_SATURATION = 3'd1,
    CFG_BRIGHTNESS = 3'd2,
    CFG_BACK_MODE  = 3'd3,
    CFG_INVERT     = 3'd4,
    CFG_COLOR_EN   = 3'd5
  } cfg_idx_t;

  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_t;

  typedef struct packed {
    logic [7:0]  character;
    logic [15:0] line_offset;
    logic [11:0] column;
  } rhc_in_t;

  typedef struct packed {
    logic [7:0] character_out;
    logic [7:0] text_red;
    logic [7:0] text_green;
    logic [7:0] text_blue;
    logic [7:0] back_red;
    logic [7:0] back_green;
    logic [7:0] back_blue;
    logic       text_color_valid;
    logic       back_color_valid;
  } rhc_out_t;

  typedef struct packed {
    logic [7:0] hue_step;
    logic [6:0] sat;
    logic [6:0] val;
    logic       background_mode;
    logic       invert_text;
    logic       color_enable;
  } rhc_cfg_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] character;
    sector_t    sector;
    logic [5:0] frac;
  } rhc_hue_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] character;
    sector_t    sector;
    logic [7:0] cv;
    logic [7:0] cp;
    logic [7:0] cq;
    logic [7:0] ct;
  } rhc_chan_t;

endpackage

@@ hw/rtl/rhc_hue.sv @@
// hue pipeline: offset plus column times step, modulo 360, split into sector and fraction
`timescale 1ns / 1ps

module rhc_hue
  import rhc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  rhc_in_t   in_word,
  input  rhc_cfg_t  cfg,
  output rhc_hue_t  hue_out
);

  logic        v1_r, v2_r, v3_r, v4_r;
  logic        v1_nxt, v2_nxt, v3_nxt, v4_nxt;
  logic [7:0]  ch1_r, ch2_r, ch3_r, ch4_r;
  logic [20:0] sum1_r, sum2_r;
  logic [20:0] sum1_nxt;
  logic [42:0] prod2_r;
  logic [42:0] prod2_nxt;
  logic [8:0]  hue3_r;
  logic [8:0]  hue3_nxt;
  logic [11:0] quot;
  logic [20:0] quot_x360;
  sector_t     sec4_r, sec4_nxt;
  logic [5:0]  frac4_r, frac4_nxt;
  logic [8:0]  sec_base;

  assign v1_nxt   = in_valid;
  assign v2_nxt   = v1_r;
  assign v3_nxt   = v2_r;
  assign v4_nxt   = v3_r;

  // stage 1: exact hue sum
  assign sum1_nxt = 21'(in_word.line_offset) + 21'(in_word.column) * 21'(cfg.hue_step);

  // stage 2: reciprocal multiply for the quotient by 360
  assign prod2_nxt = 43'(sum1_r) * 43'(RECIP_360);

  // stage 3: remainder
  assign quot      = prod2_r[SHIFT_360 +: 12];
  assign quot_x360 = 21'(quot) * 21'(HUE_FULL);
  assign hue3_nxt  = 9'(sum2_r - quot_x360);

  // stage 4: sector and position inside it
  always_comb begin
    if (hue3_r >= 9'(5 * SECTOR_SPAN)) begin
      sec4_nxt = SEC_MAG_RED;
      sec_base = 9'(5 * SECTOR_SPAN);
    end else if (hue3_r >= 9'(4 * SECTOR_SPAN)) begin
      sec4_nxt = SEC_BLU_MAG;
      sec_base = 9'(4 * SECTOR_SPAN);
    end else if (hue3_r >= 9'(3 * SECTOR_SPAN)) begin
      sec4_nxt = SEC_CYN_BLU;
      sec_base = 9'(3 * SECTOR_SPAN);
    end else if (hue3_r >= 9'(2 * SECTOR_SPAN)) begin
      sec4_nxt = SEC_GRN_CYN;
      sec_base = 9'(2 * SECTOR_SPAN);
    end else if (hue3_r >= 9'(SECTOR_SPAN)) begin
      sec4_nxt = SEC_YEL_GRN;
      sec_base = 9'(SECTOR_SPAN);
    end else begin
      sec4_nxt = SEC_RED_YEL;
      sec_base = 9'd0;
    end
    frac4_nxt = 6'(hue3_r - sec_base);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
      v4_r <= v4_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ch1_r   <= in_word.character;
    sum1_r  <= sum1_nxt;
    ch2_r   <= ch1_r;
    sum2_r  <= sum1_r;
    prod2_r <= prod2_nxt;
    ch3_r   <= ch2_r;
    hue3_r  <= hue3_nxt;
    ch4_r   <= ch3_r;
    sec4_r  <= sec4_nxt;
    frac4_r <= frac4_nxt;
  end

  assign hue_out.valid     = v4_r;
  assign hue_out.character = ch4_r;
  assign hue_out.sector    = sec4_r;
  assign hue_out.frac      = frac4_r;

endmodule

@@ hw/rtl/rhc_chan.sv @@
// channel pipeline: numerators, scaling by value and exact division by 600000
`timescale 1ns / 1ps

module rhc_chan
  import rhc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  rhc_hue_t  hue_in,
  input  rhc_cfg_t  cfg,
  output rhc_chan_t chan_out
);

  logic        v5_r, v6_r, v7_r;
  logic        v5_nxt, v6_nxt, v7_nxt;
  logic [7:0]  ch5_r, ch6_r, ch7_r;
  sector_t     sec5_r, sec6_r, sec7_r;
  logic [12:0] np5_r, nq5_r, nt5_r;
  logic [12:0] np5_nxt, nq5_nxt, nt5_nxt;
  logic [14:0] v255;
  logic [27:0] xv6_r, xp6_r, xq6_r, xt6_r;
  logic [27:0] xv6_nxt, xp6_nxt, xq6_nxt, xt6_nxt;
  logic [56:0] pv7_r, pp7_r, pq7_r, pt7_r;
  logic [56:0] pv7_nxt, pp7_nxt, pq7_nxt, pt7_nxt;

  assign v5_nxt = hue_in.valid;
  assign v6_nxt = v5_r;
  assign v7_nxt = v6_r;

  // stage 5: numerators
  assign np5_nxt = 13'(FULL_SCALE) - 13'(cfg.sat) * 13'(SECTOR_SPAN);
  assign nq5_nxt = 13'(FULL_SCALE) - 13'(cfg.sat) * 13'(hue_in.frac);
  assign nt5_nxt = 13'(FULL_SCALE) - 13'(cfg.sat) * 13'(6'(SECTOR_SPAN) - hue_in.frac);

  // stage 6: value times 255 times numerator
  assign v255    = {cfg.val, 8'd0} - 15'(cfg.val);
  assign xv6_nxt = 28'(v255) * 28'(FULL_SCALE);
  assign xp6_nxt = 28'(v255) * 28'(np5_r);
  assign xq6_nxt = 28'(v255) * 28'(nq5_r);
  assign xt6_nxt = 28'(v255) * 28'(nt5_r);

  // stage 7: reciprocal multiply for the quotient by 600000
  assign pv7_nxt = 57'(xv6_r) * 57'(RECIP_CHAN);
  assign pp7_nxt = 57'(xp6_r) * 57'(RECIP_CHAN);
  assign pq7_nxt = 57'(xq6_r) * 57'(RECIP_CHAN);
  assign pt7_nxt = 57'(xt6_r) * 57'(RECIP_CHAN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else begin
      v5_r <= v5_nxt;
      v6_r <= v6_nxt;
      v7_r <= v7_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ch5_r  <= hue_in.character;
    sec5_r <= hue_in.sector;
    np5_r  <= np5_nxt;
    nq5_r  <= nq5_nxt;
    nt5_r  <= nt5_nxt;
    ch6_r  <= ch5_r;
    sec6_r <= sec5_r;
    xv6_r  <= xv6_nxt;
    xp6_r  <= xp6_nxt;
    xq6_r  <= xq6_nxt;
    xt6_r  <= xt6_nxt;
    ch7_r  <= ch6_r;
    sec7_r <= sec6_r;
    pv7_r  <= pv7_nxt;
    pp7_r  <= pp7_nxt;
    pq7_r  <= pq7_nxt;
    pt7_r  <= pt7_nxt;
  end

  assign chan_out.valid     = v7_r;
  assign chan_out.character = ch7_r;
  assign chan_out.sector    = sec7_r;
  assign chan_out.cv        = pv7_r[SHIFT_CHAN +: 8];
  assign chan_out.cp        = pp7_r[SHIFT_CHAN +: 8];
  assign chan_out.cq        = pq7_r[SHIFT_CHAN +: 8];
  assign chan_out.ct        = pt7_r[SHIFT_CHAN +: 8];

endmodule

@@ hw/rtl/rhc_route.sv @@
// sector select and text / background routing into the output register
`timescale 1ns / 1ps

module rhc_route
  import rhc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  rhc_chan_t chan_in,
  input  rhc_cfg_t  cfg,
  output logic      out_valid,
  output rhc_out_t  out_data
);

  logic       valid_r, valid_nxt;
  rhc_out_t   data_r, data_nxt;
  logic [7:0] red, green, blue;
  logic       tvalid, bvalid, inv;

  always_comb begin
    case (chan_in.sector)
      SEC_RED_YEL: begin red = chan_in.cv; green = chan_in.ct; blue = chan_in.cp; end
      SEC_YEL_GRN: begin red = chan_in.cq; green = chan_in.cv; blue = chan_in.cp; end
      SEC_GRN_CYN: begin red = chan_in.cp; green = chan_in.cv; blue = chan_in.ct; end
      SEC_CYN_BLU: begin red = chan_in.cp; green = chan_in.cq; blue = chan_in.cv; end
      SEC_BLU_MAG: begin red = chan_in.ct; green = chan_in.cp; blue = chan_in.cv; end
      default: begin red = chan_in.cv; green = chan_in.cp; blue = chan_in.cq; end
    endcase
  end

  assign bvalid = cfg.color_enable & cfg.background_mode;
  assign tvalid = cfg.color_enable & (~cfg.background_mode | cfg.invert_text);
  assign inv    = cfg.background_mode & cfg.invert_text;

  always_comb begin
    valid_nxt                 = chan_in.valid;
    data_nxt.character_out    = chan_in.character;
    data_nxt.back_color_valid = bvalid;
    data_nxt.text_color_valid = tvalid;
    data_nxt.back_red         = bvalid ? red : 8'd0;
    data_nxt.back_green       = bvalid ? green : 8'd0;
    data_nxt.back_blue        = bvalid ? blue : 8'd0;
    if (!tvalid) begin
      data_nxt.text_red   = 8'd0;
      data_nxt.text_green = 8'd0;
      data_nxt.text_blue  = 8'd0;
    end else if (inv) begin
      data_nxt.text_red   = ~red;
      data_nxt.text_green = ~green;
      data_nxt.text_blue  = ~blue;
    end else begin
      data_nxt.text_red   = red;
      data_nxt.text_green = green;
      data_nxt.text_blue  = blue;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

@@ hw/rtl/rainbow_hue_to_rgb_colorizer_top.sv @@
// top level of the rainbow hue to rgb colorizer: config registers and pipeline
`timescale 1ns / 1ps

// One character word is taken on every cycle that start is high; busy is
// always low. Each word gives one result word on out_data, marked by a
// one-cycle out_valid, in order. The
// receiver cannot stall the output. The 8 stages are hue sum, divide by
// 360 by reciprocal, remainder, sector split, channel numerators, value
// scaling, divide by 600000 by reciprocal, and sector select with
// text / background routing. Configuration is written through cfg_we,
// cfg_idx and cfg_wdata and takes effect on the next cycle; change it
// only while no word is in flight.

module rainbow_hue_to_rgb_colorizer_top
  import rhc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  rhc_in_t    in_data,
  output logic       out_valid,
  output rhc_out_t   out_data,
  input  logic       cfg_we,
  input  logic [2:0] cfg_idx,
  input  logic [7:0] cfg_wdata
);

  logic [7:0] hue_step_r;
  logic [6:0] saturation_r;
  logic [6:0] brightness_r;
  logic       back_mode_r;
  logic       invert_r;
  logic       color_en_r;
  rhc_cfg_t   cfg;
  rhc_hue_t   hue_word;
  rhc_chan_t  chan_word;
  logic       accept;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hue_step_r   <= 8'd4;
      saturation_r <= 7'd80;
      brightness_r <= 7'd100;
      back_mode_r  <= 1'b0;
      invert_r     <= 1'b0;
      color_en_r   <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_HUE_STEP:   hue_step_r   <= cfg_wdata;
        CFG_SATURATION: saturation_r <= cfg_wdata[6:0];
        CFG_BRIGHTNESS: brightness_r <= cfg_wdata[6:0];
        CFG_BACK_MODE:  back_mode_r  <= cfg_wdata[0];
        CFG_INVERT:     invert_r     <= cfg_wdata[0];
        CFG_COLOR_EN:   color_en_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // percentages above 100 clamp to 100
  assign cfg.hue_step        = hue_step_r;
  assign cfg.sat             = (saturation_r > 7'(PCT_MAX)) ? 7'(PCT_MAX) : saturation_r;
  assign cfg.val             = (brightness_r > 7'(PCT_MAX)) ? 7'(PCT_MAX) : brightness_r;
  assign cfg.background_mode = back_mode_r;
  assign cfg.invert_text     = invert_r;
  assign cfg.color_enable    = color_en_r;

  rhc_hue u_hue (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (accept),
    .in_word  (in_data),
    .cfg      (cfg),
    .hue_out  (hue_word)
  );

  rhc_chan u_chan (
    .clk      (clk),
    .rst_n    (rst_n),
    .hue_in   (hue_word),
    .cfg      (cfg),
    .chan_out (chan_word)
  );

  rhc_route u_route (
    .clk       (clk),
    .rst_n     (rst_n),
    .chan_in   (chan_word),
    .cfg       (cfg),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // each accepted word gives a result strobe after passing the hue, channel and route pipelines
  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n, 1) && $past(rst_n, 2) && $past(rst_n, 3) && $past(rst_n, 4) &&
     $past(rst_n, 5) && $past(rst_n, 6) && $past(rst_n, 7) && $past(rst_n, 8))
    |-> (out_valid == $past(accept, 8)))
    else $error("result strobe does not match accepted word");

  a_text_off : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.text_color_valid) |->
    (out_data.text_red == 8'd0 && out_data.text_green == 8'd0 &&
     out_data.text_blue == 8'd0))
    else $error("text color not cleared while disabled");

  a_inverted : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.text_color_valid && out_data.back_color_valid) |->
    (out_data.text_red == ~out_data.back_red &&
     out_data.text_green == ~out_data.back_green &&
     out_data.text_blue == ~out_data.back_blue))
    else $error("inverted text does not mirror background");

endmodule

@@ test/rainbow_hue_to_rgb_colorizer_top_tb.sv @@
// testbench for the rainbow colorizer: directed table plus random words checked against a color predictor
`timescale 1ns / 1ps

module rainbow_hue_to_rgb_colorizer_top_tb;
  import rhc_pkg::*;

  localparam int unsigned LATENCY         = 8;
  localparam int unsigned CYCLE_LIMIT     = 200000;
  localparam int unsigned PHASES          = 12;
  localparam int unsigned WORDS_PER_PHASE = 40;
  localparam logic [2:0]  CFG_UNUSED      = 3'd6;

  typedef struct packed {
    logic [7:0] step;
    logic [7:0] sat;
    logic [7:0] val;
    logic       bg;
    logic       inv;
    logic       en;
  } knob_set_t;

  typedef struct {
    knob_set_t knobs;
    rhc_in_t   word;
    bit        typed;
    rhc_out_t  want;
  } dir_row_t;

  localparam knob_set_t RESET_KNOBS = '{8'd4, 8'd80, 8'd100, 1'b0, 1'b0, 1'b1};

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  rhc_in_t    in_data = '0;
  logic       out_valid;
  rhc_out_t   out_data;
  logic       cfg_we = 1'b0;
  logic [2:0] cfg_idx = '0;
  logic [7:0] cfg_wdata = '0;

  // register copies at the block's widths
  logic [7:0] m_step = 8'd4;
  logic [6:0] m_sat = 7'd80;
  logic [6:0] m_val = 7'd100;
  logic       m_bg = 1'b0;
  logic       m_inv = 1'b0;
  logic       m_en = 1'b1;

  knob_set_t   cur_knobs = RESET_KNOBS;
  rhc_out_t    pending_colors[$];
  dir_row_t    dir_rows[$];
  bit          use_typed = 1'b0;
  rhc_out_t    typed_want = '0;
  int unsigned idle_pct = 10;
  int unsigned words_taken = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;
  int unsigned settings_done = 0;
  int unsigned cycles = 0;

  rainbow_hue_to_rgb_colorizer_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int unsigned scale_chan(int unsigned v, int unsigned num);
    return (v * CHAN_MAX * num) / (FULL_SCALE * PCT_MAX);
  endfunction

  function automatic rhc_out_t hue_to_word(rhc_in_t w);
    int unsigned hue, f, s, v, cv, cp, cq, ct, r, g, b;
    sector_t     sec;
    rhc_out_t    o;
    o = '0;
    hue = (int'(w.line_offset) + int'(w.column) * int'(m_step)) % HUE_FULL;
    sec = sector_t'(hue / SECTOR_SPAN);
    f = hue % SECTOR_SPAN;
    s = (m_sat > PCT_MAX) ? PCT_MAX : int'(m_sat);
    v = (m_val > PCT_MAX) ? PCT_MAX : int'(m_val);
    cv = scale_chan(v, FULL_SCALE);
    cp = scale_chan(v, FULL_SCALE - SECTOR_SPAN * s);
    cq = scale_chan(v, FULL_SCALE - s * f);
    ct = scale_chan(v, FULL_SCALE - s * (SECTOR_SPAN - f));
    case (sec)
      SEC_RED_YEL: begin r = cv; g = ct; b = cp; end
      SEC_YEL_GRN: begin r = cq; g = cv; b = cp; end
      SEC_GRN_CYN: begin r = cp; g = cv; b = ct; end
      SEC_CYN_BLU: begin r = cp; g = cq; b = cv; end
      SEC_BLU_MAG: begin r = ct; g = cp; b = cv; end
      default:     begin r = cv; g = cp; b = cq; end
    endcase
    o.character_out = w.character;
    o.back_color_valid = m_en && m_bg;
    o.text_color_valid = m_en && (!m_bg || m_inv);
    if (o.back_color_valid) begin
      o.back_red = r[7:0];
      o.back_green = g[7:0];
      o.back_blue = b[7:0];
    end
    if (o.text_color_valid) begin
      if (m_bg && m_inv) begin
        o.text_red = 8'(CHAN_MAX - r);
        o.text_green = 8'(CHAN_MAX - g);
        o.text_blue = 8'(CHAN_MAX - b);
      end else begin
        o.text_red = r[7:0];
        o.text_green = g[7:0];
        o.text_blue = b[7:0];
      end
    end
    return o;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : color_monitor
    rhc_out_t want;
    if (rst_n) begin
      if (start && !busy) begin
        pending_colors.push_back(use_typed ? typed_want : hue_to_word(in_data));
        words_taken++;
      end
      if (out_valid) begin
        results_seen++;
        if (pending_colors.size() == 0) begin
          $error("result word with nothing expected: %h", out_data);
          mismatches++;
        end else begin
          want = pending_colors.pop_front();
          check_field("character_out", want.character_out, out_data.character_out);
          check_field("text_red", want.text_red, out_data.text_red);
          check_field("text_green", want.text_green, out_data.text_green);
          check_field("text_blue", want.text_blue, out_data.text_blue);
          check_field("back_red", want.back_red, out_data.back_red);
          check_field("back_green", want.back_green, out_data.back_green);
          check_field("back_blue", want.back_blue, out_data.back_blue);
          check_field("text_color_valid", want.text_color_valid, out_data.text_color_valid);
          check_field("back_color_valid", want.back_color_valid, out_data.back_color_valid);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_word(input rhc_in_t w, input bit typed, input rhc_out_t want);
    int unsigned target;
    target = words_taken + 1;
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_data <= w;
    use_typed = typed;
    typed_want = want;
    wait (words_taken == target);
  endtask

  task automatic write_knob(input logic [2:0] idx, input logic [7:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_HUE_STEP:   m_step = data;
      CFG_SATURATION: m_sat = data[6:0];
      CFG_BRIGHTNESS: m_val = data[6:0];
      CFG_BACK_MODE:  m_bg = data[0];
      CFG_INVERT:     m_inv = data[0];
      CFG_COLOR_EN:   m_en = data[0];
      default: ;
    endcase
  endtask

  task automatic apply_knobs(input knob_set_t k);
    @(negedge clk);
    start <= 1'b0;
    wait (pending_colors.size() == 0);
    write_knob(CFG_HUE_STEP, k.step);
    write_knob(CFG_SATURATION, k.sat);
    write_knob(CFG_BRIGHTNESS, k.val);
    write_knob(CFG_BACK_MODE, {7'd0, k.bg});
    write_knob(CFG_INVERT, {7'd0, k.inv});
    write_knob(CFG_COLOR_EN, {7'd0, k.en});
    write_knob(CFG_UNUSED, 8'($urandom_range(255)));
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_knobs = k;
    settings_done++;
  endtask

  initial begin : stimulus
    knob_set_t grey_k, dark_k, over_k, back_k, binv_k, off_k, offi_k, wide_k, zstep_k, k;
    rhc_in_t   w;
    grey_k  = '{8'd4, 8'd0, 8'd100, 1'b0, 1'b0, 1'b1};
    dark_k  = '{8'd4, 8'd80, 8'd0, 1'b0, 1'b0, 1'b1};
    over_k  = '{8'd4, 8'd127, 8'd127, 1'b0, 1'b0, 1'b1};
    back_k  = '{8'd4, 8'd80, 8'd100, 1'b1, 1'b0, 1'b1};
    binv_k  = '{8'd4, 8'd80, 8'd100, 1'b1, 1'b1, 1'b1};
    off_k   = '{8'd4, 8'd80, 8'd100, 1'b0, 1'b0, 1'b0};
    offi_k  = '{8'd4, 8'd80, 8'd100, 1'b1, 1'b1, 1'b0};
    wide_k  = '{8'd255, 8'd100, 8'd100, 1'b0, 1'b1, 1'b1};
    zstep_k = '{8'd0, 8'he4, 8'hc0, 1'b0, 1'b0, 1'b1};

    dir_rows.push_back('{RESET_KNOBS, rhc_in_t'{8'h41, 16'd0, 12'd0}, 1'b1,
      rhc_out_t'{8'h41, 8'd255, 8'd51, 8'd51, 8'd0, 8'd0, 8'd0, 1'b1, 1'b0}});
    dir_rows.push_back('{RESET_KNOBS, rhc_in_t'{8'h00, 16'd360, 12'd0}, 1'b1,
      rhc_out_t'{8'h00, 8'd255, 8'd51, 8'd51, 8'd0, 8'd0, 8'd0, 1'b1, 1'b0}});
    dir_rows.push_back('{RESET_KNOBS, rhc_in_t'{8'hff, 16'hffff, 12'hfff}, 1'b0, '0});
    dir_rows.push_back('{RESET_KNOBS, rhc_in_t'{8'h80, 16'd59, 12'd0}, 1'b0, '0});
    dir_rows.push_back('{RESET_KNOBS, rhc_in_t'{8'h7f, 16'd60, 12'd0}, 1'b0, '0});
    dir_rows.push_back('{RESET_KNOBS, rhc_in_t'{8'h01, 16'd120, 12'd0}, 1'b0, '0});
    dir_rows.push_back('{RESET_KNOBS, rhc_in_t'{8'h02, 16'd180, 12'd0}, 1'b0, '0});
    dir_rows.push_back('{RESET_KNOBS, rhc_in_t'{8'h03, 16'd240, 12'd0}, 1'b0, '0});
    dir_rows.push_back('{RESET_KNOBS, rhc_in_t'{8'h04, 16'd300, 12'd0}, 1'b0, '0});
    dir_rows.push_back('{RESET_KNOBS, rhc_in_t'{8'h05, 16'd359, 12'd0}, 1'b0, '0});
    dir_rows.push_back('{RESET_KNOBS, rhc_in_t'{8'h06, 16'd0, 12'd90}, 1'b0, '0});
    dir_rows.push_back('{grey_k, rhc_in_t'{8'h20, 16'd123, 12'd7}, 1'b1,
      rhc_out_t'{8'h20, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 1'b1, 1'b0}});
    dir_rows.push_back('{dark_k, rhc_in_t'{8'h21, 16'd200, 12'd3}, 1'b1,
      rhc_out_t'{8'h21, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b0}});
    dir_rows.push_back('{over_k, rhc_in_t'{8'h22, 16'd30, 12'd1}, 1'b0, '0});
    dir_rows.push_back('{back_k, rhc_in_t'{8'h23, 16'd100, 12'd10}, 1'b0, '0});
    dir_rows.push_back('{binv_k, rhc_in_t'{8'h24, 16'd350, 12'd2}, 1'b0, '0});
    dir_rows.push_back('{binv_k, rhc_in_t'{8'h25, 16'd0, 12'd0}, 1'b1,
      rhc_out_t'{8'h25, 8'd0, 8'd204, 8'd204, 8'd255, 8'd51, 8'd51, 1'b1, 1'b1}});
    dir_rows.push_back('{off_k, rhc_in_t'{8'h26, 16'd1000, 12'd1000}, 1'b1,
      rhc_out_t'{8'h26, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0}});
    dir_rows.push_back('{offi_k, rhc_in_t'{8'h27, 16'd5, 12'd5}, 1'b1,
      rhc_out_t'{8'h27, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0}});
    dir_rows.push_back('{wide_k, rhc_in_t'{8'h28, 16'hffff, 12'hfff}, 1'b0, '0});
    dir_rows.push_back('{wide_k, rhc_in_t'{8'h29, 16'd0, 12'hfff}, 1'b0, '0});
    dir_rows.push_back('{zstep_k, rhc_in_t'{8'h2a, 16'hffff, 12'hfff}, 1'b0, '0});

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    idle_pct = 10;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].knobs != cur_knobs) apply_knobs(dir_rows[i].knobs);
      send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].want);
    end

    for (int p = 0; p < PHASES; p++) begin
      idle_pct = (p < 4) ? 10 : ((p < 8) ? 78 : 0);
      case (p)
        0: k = '{8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0};
        1: k = '{8'd255, 8'd127, 8'd127, 1'b1, 1'b1, 1'b1};
        2: k = '{8'd255, 8'd100, 8'd100, 1'b1, 1'b0, 1'b1};
        default: begin
          k.step = 8'($urandom_range(255));
          case ($urandom_range(3))
            0, 1: k.sat = 8'($urandom_range(100));
            2: k.sat = 8'($urandom_range(127, 101));
            default: k.sat = 8'($urandom_range(255));
          endcase
          case ($urandom_range(3))
            0, 1: k.val = 8'($urandom_range(100));
            2: k.val = 8'($urandom_range(127, 101));
            default: k.val = 8'($urandom_range(255));
          endcase
          k.bg = 1'($urandom_range(1));
          k.inv = 1'($urandom_range(1));
          k.en = ($urandom_range(3) != 0);
        end
      endcase
      apply_knobs(k);
      repeat (WORDS_PER_PHASE) begin
        w.character = 8'($urandom_range(255));
        case ($urandom_range(3))
          0: w.line_offset = 16'($urandom_range(65535));
          1: w.line_offset = 16'($urandom_range(719));
          2: w.line_offset = 16'(65535 - $urandom_range(15));
          default: w.line_offset = 16'(60 * $urandom_range(11) + 59 * $urandom_range(1));
        endcase
        case ($urandom_range(3))
          0: w.column = 12'($urandom_range(4095));
          1: w.column = 12'($urandom_range(63));
          2: w.column = 12'd4095;
          default: w.column = 12'($urandom_range(399));
        endcase
        send_word(w, 1'b0, '0);
      end
    end

    @(negedge clk);
    start <= 1'b0;
    wait (pending_colors.size() == 0);
    repeat (LATENCY + 4) @(posedge clk);

    $display("summary: %0d words sent under %0d register settings, %0d results checked",
             words_taken, settings_done + 1, results_seen);
    $display("summary: all sectors, grey, black, clamped, background and inverted routing; %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
